FILE: design/bssc_pkg.sv
// bssc_pkg: shared types, constants and helpers for the box screen-space cull block.
// No dependencies; used by every module of the block.
package bssc_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORNER_COUNT = 8;
    localparam int CORNER_W     = $clog2(CORNER_COUNT);
    localparam int COEF_SLOTS   = 24;
    localparam int COEF_IDX_W   = 5;
    localparam int MAT_ENTRIES  = 12;
    localparam int DATA_W       = 32;
    localparam int MUL_W        = 2 * DATA_W;
    localparam int PROD_W       = MUL_W - FRAC_BITS;
    localparam int SUM_W        = PROD_W + 2;
    localparam int NUM_W        = DATA_W + FRAC_BITS;
    localparam int DIV_STEP     = 4;
    localparam int DIV_STAGES   = (NUM_W + DIV_STEP - 1) / DIV_STEP;
    localparam int NUM_PAD      = DIV_STAGES * DIV_STEP;
    localparam int REM_W        = DATA_W + 1;
    localparam int FLIGHT_W     = 4;
    localparam int CFG_IDX_W    = 3;

    typedef logic signed [DATA_W-1:0] fx_t;
    typedef logic [MAT_ENTRIES-1:0][DATA_W-1:0] mat_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic kept;
    } ctl_t;

    localparam fx_t FX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam fx_t FX_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam fx_t FX_ONE = fx_t'(1) <<< FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_CLIP_X_ORIGIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_X_EXTENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_Y_ORIGIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_Y_EXTENT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_NEAR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_FAR     = 3'd5;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    function automatic fx_t sat_fx(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(FX_MAX))
            return FX_MAX;
        else if (v < SUM_W'(FX_MIN))
            return FX_MIN;
        else
            return fx_t'(v);
    endfunction

endpackage

FILE: design/bssc_xform.sv
// bssc_xform: two-stage 3x4 affine transform of one corner (products, then row sums).
// Depends on bssc_pkg.
module bssc_xform (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  bssc_pkg::ctl_t  ctl_in,
    input  bssc_pkg::mat_t  coef,
    input  bssc_pkg::fx_t   x,
    input  bssc_pkg::fx_t   y,
    input  bssc_pkg::fx_t   z,
    output bssc_pkg::ctl_t  ctl_out,
    output bssc_pkg::fx_t   ox,
    output bssc_pkg::fx_t   oy,
    output bssc_pkg::fx_t   oz
);

    bssc_pkg::ctl_t ctl1_reg;
    bssc_pkg::ctl_t ctl2_reg;
    logic signed [bssc_pkg::PROD_W-1:0] prod_reg [3][3];
    logic signed [bssc_pkg::PROD_W-1:0] prod_next [3][3];
    bssc_pkg::fx_t  vin [3];
    bssc_pkg::fx_t  row_reg [3];
    bssc_pkg::fx_t  row_next [3];

    assign vin[0] = x;
    assign vin[1] = y;
    assign vin[2] = z;

    // entry for row r, column c sits at 3*c + r
    always_comb
    begin
        logic signed [bssc_pkg::MUL_W-1:0] full;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                full = bssc_pkg::MUL_W'(bssc_pkg::fx_t'(coef[3*c+r]))
                     * bssc_pkg::MUL_W'(vin[c]);
                prod_next[r][c] = full[bssc_pkg::MUL_W-1:bssc_pkg::FRAC_BITS];
            end
        end
    end

    always_comb
    begin
        logic signed [bssc_pkg::SUM_W-1:0] acc;
        for (int r = 0; r < 3; r++)
        begin
            acc = bssc_pkg::SUM_W'(prod_reg[r][0]) + bssc_pkg::SUM_W'(prod_reg[r][1])
                + bssc_pkg::SUM_W'(prod_reg[r][2])
                + bssc_pkg::SUM_W'(bssc_pkg::fx_t'(coef[9+r]));
            row_next[r] = bssc_pkg::sat_fx(acc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            row_reg  <= row_next;
        end
    end

    assign ctl_out = ctl2_reg;
    assign ox      = row_reg[0];
    assign oy      = row_reg[1];
    assign oz      = row_reg[2];

endmodule

FILE: design/bssc_div.sv
// bssc_div: pipelined two-lane signed Q divider, DIV_STEP quotient bits per stage,
// saturating to 32 bits. Depends on bssc_pkg.
module bssc_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  bssc_pkg::ctl_t  ctl_in,
    input  bssc_pkg::fx_t   num_x,
    input  bssc_pkg::fx_t   num_y,
    input  bssc_pkg::fx_t   den,
    output bssc_pkg::ctl_t  ctl_out,
    output bssc_pkg::fx_t   q_x,
    output bssc_pkg::fx_t   q_y
);

    localparam int S = bssc_pkg::DIV_STAGES;

    typedef struct packed {
        logic [bssc_pkg::REM_W-1:0]   rem;
        logic [bssc_pkg::NUM_PAD-1:0] num;
        logic [bssc_pkg::NUM_PAD-1:0] quo;
    } div_st_t;

    typedef struct packed {
        bssc_pkg::ctl_t              ctl;
        logic                        dz;
        logic [bssc_pkg::DATA_W-1:0] dmag;
        logic [1:0]                  neg;
        logic [1:0]                  nneg;
    } side_t;

    localparam logic [bssc_pkg::NUM_PAD-1:0] LIM_POS = bssc_pkg::NUM_PAD'(bssc_pkg::FX_MAX);
    localparam logic [bssc_pkg::NUM_PAD-1:0] LIM_NEG = LIM_POS + 1'b1;

    function automatic logic [bssc_pkg::DATA_W-1:0] mag(input bssc_pkg::fx_t v);
        return v[bssc_pkg::DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic div_st_t div_step(input div_st_t s,
                                         input logic [bssc_pkg::DATA_W-1:0] d);
        div_st_t t;
        logic [bssc_pkg::REM_W-1:0] r;
        logic b;
        t = s;
        for (int i = 0; i < bssc_pkg::DIV_STEP; i++)
        begin
            r = {t.rem[bssc_pkg::REM_W-2:0], t.num[bssc_pkg::NUM_PAD-1]};
            t.num = t.num << 1;
            b = (r >= {1'b0, d});
            if (b)
                r = r - {1'b0, d};
            t.rem = r;
            t.quo = {t.quo[bssc_pkg::NUM_PAD-2:0], b};
        end
        return t;
    endfunction

    bssc_pkg::fx_t num_in [2];
    div_st_t       st_in  [2][S];
    div_st_t       st_next[2][S];
    div_st_t       st_reg [2][S];
    side_t         side_in [S];
    side_t         side_reg[S];
    side_t         side0;
    bssc_pkg::ctl_t ctl_out_reg;
    bssc_pkg::fx_t  q_reg [2];
    bssc_pkg::fx_t  q_next[2];

    assign num_in[0] = num_x;
    assign num_in[1] = num_y;

    always_comb
    begin
        side0.ctl  = ctl_in;
        side0.dz   = (den == '0);
        side0.dmag = mag(den);
        for (int l = 0; l < 2; l++)
        begin
            side0.nneg[l] = num_in[l][bssc_pkg::DATA_W-1];
            side0.neg[l]  = num_in[l][bssc_pkg::DATA_W-1] ^ den[bssc_pkg::DATA_W-1];
        end
    end

    for (genvar s = 0; s < S; s++)
    begin : g_stage
        if (s == 0)
        begin : g_first
            assign side_in[s] = side0;
        end
        else
        begin : g_rest
            assign side_in[s] = side_reg[s-1];
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            if (s == 0)
            begin : g_init
                assign st_in[l][s].rem = '0;
                assign st_in[l][s].num = bssc_pkg::NUM_PAD'(
                    {mag(num_in[l]), {bssc_pkg::FRAC_BITS{1'b0}}});
                assign st_in[l][s].quo = '0;
            end
            else
            begin : g_chain
                assign st_in[l][s] = st_reg[l][s-1];
            end

            assign st_next[l][s] = div_step(st_in[l][s], side_in[s].dmag);

            always_ff @(posedge clk)
            begin
                if (en)
                    st_reg[l][s] <= st_next[l][s];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                side_reg[s] <= '0;
            else if (en)
                side_reg[s] <= side_in[s];
        end
    end

    // sign and saturation of the quotient magnitude
    always_comb
    begin
        logic [bssc_pkg::NUM_PAD-1:0] q;
        for (int l = 0; l < 2; l++)
        begin
            q = st_reg[l][S-1].quo;
            if (side_reg[S-1].dz)
                q_next[l] = side_reg[S-1].nneg[l] ? bssc_pkg::FX_MIN : bssc_pkg::FX_MAX;
            else if (side_reg[S-1].neg[l])
                q_next[l] = (q > LIM_NEG) ? bssc_pkg::FX_MIN
                          : bssc_pkg::fx_t'(~q[bssc_pkg::DATA_W-1:0] + 1'b1);
            else
                q_next[l] = (q > LIM_POS) ? bssc_pkg::FX_MAX
                          : bssc_pkg::fx_t'(q[bssc_pkg::DATA_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_out_reg <= '0;
        else if (en)
            ctl_out_reg <= side_reg[S-1].ctl;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign ctl_out = ctl_out_reg;
    assign q_x     = q_reg[0];
    assign q_y     = q_reg[1];

endmodule

FILE: design/bssc_screen.sv
// bssc_screen: three-stage viewport mapping of both screen axes.
// Depends on bssc_pkg.
module bssc_screen (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  bssc_pkg::ctl_t  ctl_in,
    input  bssc_pkg::fx_t   q_x,
    input  bssc_pkg::fx_t   q_y,
    input  bssc_pkg::fx_t   origin_x,
    input  bssc_pkg::fx_t   extent_x,
    input  bssc_pkg::fx_t   origin_y,
    input  bssc_pkg::fx_t   extent_y,
    output bssc_pkg::ctl_t  ctl_out,
    output bssc_pkg::fx_t   sx,
    output bssc_pkg::fx_t   sy
);

    bssc_pkg::ctl_t ctl_reg [3];
    bssc_pkg::fx_t  q_in [2];
    bssc_pkg::fx_t  org [2];
    bssc_pkg::fx_t  ext [2];
    bssc_pkg::fx_t  s1_reg [2];
    bssc_pkg::fx_t  s1_next [2];
    logic signed [bssc_pkg::MUL_W-1:0] m_reg [2];
    logic signed [bssc_pkg::MUL_W-1:0] m_next [2];
    bssc_pkg::fx_t  s3_reg [2];
    bssc_pkg::fx_t  s3_next [2];

    assign q_in[0] = q_x;
    assign q_in[1] = q_y;
    assign org[0]  = origin_x;
    assign org[1]  = origin_y;
    assign ext[0]  = extent_x;
    assign ext[1]  = extent_y;

    always_comb
    begin
        logic signed [bssc_pkg::MUL_W-bssc_pkg::FRAC_BITS-2:0] half;
        for (int l = 0; l < 2; l++)
        begin
            s1_next[l] = bssc_pkg::sat_fx(bssc_pkg::SUM_W'(bssc_pkg::FX_ONE)
                                        + bssc_pkg::SUM_W'(q_in[l]));
            m_next[l]  = bssc_pkg::MUL_W'(s1_reg[l]) * bssc_pkg::MUL_W'(ext[l]);
            // floor shift by one more bit halves the extent
            half       = m_reg[l][bssc_pkg::MUL_W-1:bssc_pkg::FRAC_BITS+1];
            s3_next[l] = bssc_pkg::sat_fx(bssc_pkg::SUM_W'(half)
                                        + bssc_pkg::SUM_W'(org[l]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
            ctl_reg[1] <= '0;
            ctl_reg[2] <= '0;
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
            ctl_reg[1] <= ctl_reg[0];
            ctl_reg[2] <= ctl_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            m_reg  <= m_next;
            s3_reg <= s3_next;
        end
    end

    assign ctl_out = ctl_reg[2];
    assign sx      = s3_reg[0];
    assign sy      = s3_reg[1];

endmodule

FILE: design/box_screen_space_cull.sv
// box_screen_space_cull: top level; coefficient store, corner sequencer, min/max reduction.
// Depends on bssc_pkg, bssc_xform, bssc_div, bssc_screen.
//
// A test request is taken when the sequencer is idle or issuing the last corner of a box;
// it issues one box corner per cycle unless the output stalls, into a fully pipelined
// path (view and projection transforms, a divider retiring four quotient bits per stage,
// viewport mapping) at 16 fraction bits. A load request is held off until no test request
// is in flight, so that every test sees the coefficients in force when it was taken.
// Output stall freezes the pipeline only while a finished result is waiting behind an
// occupied output register.
module box_screen_space_cull (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 cmd,
    input  logic [bssc_pkg::COEF_IDX_W-1:0]      coef_index,
    input  bssc_pkg::fx_t                        coef_value,
    input  bssc_pkg::fx_t                        box_min_x,
    input  bssc_pkg::fx_t                        box_min_y,
    input  bssc_pkg::fx_t                        box_min_z,
    input  bssc_pkg::fx_t                        box_max_x,
    input  bssc_pkg::fx_t                        box_max_y,
    input  bssc_pkg::fx_t                        box_max_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 visible,
    input  logic                                 cfg_wr_en,
    input  logic [bssc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bssc_pkg::DATA_W-1:0]          cfg_data
);

    localparam logic [bssc_pkg::CORNER_W-1:0] LAST_CORNER =
        bssc_pkg::CORNER_W'(bssc_pkg::CORNER_COUNT - 1);

    // configuration
    bssc_pkg::fx_t x_org_reg, x_ext_reg, y_org_reg, y_ext_reg, near_reg, far_reg;
    logic [bssc_pkg::COEF_SLOTS-1:0][bssc_pkg::DATA_W-1:0] coef_reg;

    // sequencer
    logic                          seq_active_reg;
    logic [bssc_pkg::CORNER_W-1:0] cnt_reg;
    bssc_pkg::fx_t lo_x_reg, lo_y_reg, lo_z_reg, hi_x_reg, hi_y_reg, hi_z_reg;
    bssc_pkg::ctl_t c_ctl_reg;
    bssc_pkg::fx_t  cx_reg, cy_reg, cz_reg;

    logic [bssc_pkg::FLIGHT_W-1:0] flight_reg;
    logic adv, in_acc, test_acc, load_acc, out_load, last_issue;

    bssc_pkg::ctl_t v_ctl, p_ctl, d_ctl, q_ctl, s_ctl;
    bssc_pkg::fx_t  vx, vy, vz, px, py, pz, qx, qy, sx, sy;

    // reduction
    logic          acc_any_reg, fin_valid_reg, fin_any_reg;
    bssc_pkg::fx_t acc_xmin_reg, acc_xmax_reg, acc_ymin_reg, acc_ymax_reg;
    bssc_pkg::fx_t fin_xmin_reg, fin_xmax_reg, fin_ymin_reg, fin_ymax_reg;
    logic          base_any, new_any;
    bssc_pkg::fx_t new_xmin, new_xmax, new_ymin, new_ymax;

    logic out_valid_reg, visible_reg, visible_next;

    assign adv        = !(out_valid_reg && out_stall && fin_valid_reg);
    assign last_issue = seq_active_reg && (cnt_reg == LAST_CORNER);
    assign in_stall   = (cmd == bssc_pkg::CMD_TEST)
                      ? (!adv || (seq_active_reg && !last_issue))
                      : (flight_reg != '0);
    assign in_acc     = in_valid && !in_stall;
    assign test_acc   = in_acc && (cmd == bssc_pkg::CMD_TEST);
    assign load_acc   = in_acc && (cmd == bssc_pkg::CMD_LOAD);
    assign out_load   = adv && fin_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_org_reg <= '0;
            x_ext_reg <= bssc_pkg::fx_t'(6553600);
            y_org_reg <= '0;
            y_ext_reg <= bssc_pkg::fx_t'(6553600);
            near_reg  <= bssc_pkg::fx_t'(39322);
            far_reg   <= bssc_pkg::fx_t'(334233600);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                bssc_pkg::REG_CLIP_X_ORIGIN: x_org_reg <= cfg_data;
                bssc_pkg::REG_CLIP_X_EXTENT: x_ext_reg <= cfg_data;
                bssc_pkg::REG_CLIP_Y_ORIGIN: y_org_reg <= cfg_data;
                bssc_pkg::REG_CLIP_Y_EXTENT: y_ext_reg <= cfg_data;
                bssc_pkg::REG_DEPTH_NEAR:    near_reg  <= cfg_data;
                bssc_pkg::REG_DEPTH_FAR:     far_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coef_reg <= '0;
        else if (load_acc && (coef_index < bssc_pkg::COEF_IDX_W'(bssc_pkg::COEF_SLOTS)))
            coef_reg[coef_index] <= coef_value;
    end

    // tests taken but not yet in the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flight_reg <= '0;
        else
            flight_reg <= flight_reg + bssc_pkg::FLIGHT_W'(test_acc)
                        - bssc_pkg::FLIGHT_W'(out_load);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_active_reg <= 1'b0;
            cnt_reg        <= '0;
            c_ctl_reg      <= '0;
        end
        else
        begin
            if (test_acc)
            begin
                seq_active_reg <= 1'b1;
                cnt_reg        <= '0;
            end
            else if (adv && seq_active_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_issue)
                    seq_active_reg <= 1'b0;
            end
            if (adv)
            begin
                c_ctl_reg.valid <= seq_active_reg;
                c_ctl_reg.first <= (cnt_reg == '0);
                c_ctl_reg.last  <= (cnt_reg == LAST_CORNER);
                c_ctl_reg.kept  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (test_acc)
        begin
            lo_x_reg <= box_min_x;
            lo_y_reg <= box_min_y;
            lo_z_reg <= box_min_z;
            hi_x_reg <= box_max_x;
            hi_y_reg <= box_max_y;
            hi_z_reg <= box_max_z;
        end
        if (adv)
        begin
            cx_reg <= cnt_reg[0] ? hi_x_reg : lo_x_reg;
            cy_reg <= cnt_reg[1] ? hi_y_reg : lo_y_reg;
            cz_reg <= cnt_reg[2] ? hi_z_reg : lo_z_reg;
        end
    end

    bssc_xform u_view (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .ctl_in  (c_ctl_reg),
        .coef    (coef_reg[bssc_pkg::MAT_ENTRIES-1:0]),
        .x       (cx_reg),
        .y       (cy_reg),
        .z       (cz_reg),
        .ctl_out (v_ctl),
        .ox      (vx),
        .oy      (vy),
        .oz      (vz)
    );

    bssc_xform u_proj (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .ctl_in  (v_ctl),
        .coef    (coef_reg[bssc_pkg::COEF_SLOTS-1:bssc_pkg::MAT_ENTRIES]),
        .x       (vx),
        .y       (vy),
        .z       (vz),
        .ctl_out (p_ctl),
        .ox      (px),
        .oy      (py),
        .oz      (pz)
    );

    always_comb
    begin
        d_ctl      = p_ctl;
        d_ctl.kept = (pz >= near_reg) && (pz <= far_reg);
    end

    bssc_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .ctl_in  (d_ctl),
        .num_x   (px),
        .num_y   (py),
        .den     (pz),
        .ctl_out (q_ctl),
        .q_x     (qx),
        .q_y     (qy)
    );

    bssc_screen u_screen (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .ctl_in   (q_ctl),
        .q_x      (qx),
        .q_y      (qy),
        .origin_x (x_org_reg),
        .extent_x (x_ext_reg),
        .origin_y (y_org_reg),
        .extent_y (y_ext_reg),
        .ctl_out  (s_ctl),
        .sx       (sx),
        .sy       (sy)
    );

    // running screen box; the first corner of a box restarts it
    always_comb
    begin
        base_any = s_ctl.first ? 1'b0 : acc_any_reg;
        new_any  = base_any;
        new_xmin = acc_xmin_reg;
        new_xmax = acc_xmax_reg;
        new_ymin = acc_ymin_reg;
        new_ymax = acc_ymax_reg;
        if (s_ctl.valid && s_ctl.kept)
        begin
            new_any = 1'b1;
            if (!base_any)
            begin
                new_xmin = sx;
                new_xmax = sx;
                new_ymin = sy;
                new_ymax = sy;
            end
            else
            begin
                if (sx < acc_xmin_reg) new_xmin = sx;
                if (sx > acc_xmax_reg) new_xmax = sx;
                if (sy < acc_ymin_reg) new_ymin = sy;
                if (sy > acc_ymax_reg) new_ymax = sy;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_any_reg   <= 1'b0;
            fin_valid_reg <= 1'b0;
            fin_any_reg   <= 1'b0;
        end
        else if (adv)
        begin
            if (s_ctl.valid)
                acc_any_reg <= new_any;
            fin_valid_reg <= s_ctl.valid && s_ctl.last;
            fin_any_reg   <= new_any;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s_ctl.valid)
        begin
            acc_xmin_reg <= new_xmin;
            acc_xmax_reg <= new_xmax;
            acc_ymin_reg <= new_ymin;
            acc_ymax_reg <= new_ymax;
            fin_xmin_reg <= new_xmin;
            fin_xmax_reg <= new_xmax;
            fin_ymin_reg <= new_ymin;
            fin_ymax_reg <= new_ymax;
        end
    end

    assign visible_next = fin_any_reg
                       && !(fin_xmax_reg < x_org_reg || fin_xmin_reg > x_ext_reg
                         || fin_ymax_reg < y_org_reg || fin_ymin_reg > y_ext_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            visible_reg <= visible_next;
    end

    assign out_valid = out_valid_reg;
    assign visible   = visible_reg;

endmodule
